// File: hdl/sorted_priority_queue_defines.svh
// ----------------------------------------------------------------------------
// sorted priority queue assertion macros
// shared property forms used by the port checker
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SPQ_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SPQ_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error(msg);

`endif

// File: hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// shared types, codes and widths of the sorted priority queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spq_pkg;

    // default number of queue slots
    localparam int DEPTH_DEF = 16;

    // field widths
    localparam int KIND_W   = 2;
    localparam int IDENT_W  = 16;
    localparam int PRIO_W   = 8;
    localparam int STATUS_W = 2;
    localparam int HELD_W   = 5;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK   = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic load;   // capture the operation from the input ports
        logic exec;   // apply the captured operation and register its result
    } spq_cmd_t;

endpackage

// File: hdl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// two-state sequencer: accepts a command, then runs it in the datapath
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output spq_pkg::spq_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and result strobe registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_EXEC);
        end
    end

    // commands and status
    assign busy     = (state_reg == S_EXEC);
    assign done     = done_reg;
    assign cmd.load = start && (state_reg == S_IDLE);
    assign cmd.exec = (state_reg == S_EXEC);

endmodule

// File: hdl/spq_dp.sv
// ----------------------------------------------------------------------------
// spq_dp
// row of slot cells with per-cell compare and shift, plus result registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_dp
#(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  spq_pkg::spq_cmd_t              cmd,
    input  logic [spq_pkg::KIND_W-1:0]     kind,
    input  logic [spq_pkg::IDENT_W-1:0]    job_ident,
    input  logic [spq_pkg::PRIO_W-1:0]     job_priority,
    output logic [spq_pkg::STATUS_W-1:0]   status,
    output logic [spq_pkg::IDENT_W-1:0]    out_ident,
    output logic [spq_pkg::PRIO_W-1:0]     out_priority,
    output logic [spq_pkg::HELD_W-1:0]     held_count
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    // slot storage, slot 0 is the front
    logic [spq_pkg::IDENT_W-1:0]  slot_ident_reg    [DEPTH];
    logic [spq_pkg::PRIO_W-1:0]   slot_priority_reg [DEPTH];
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;

    // captured operation
    logic [spq_pkg::KIND_W-1:0]   kind_reg;
    logic [spq_pkg::IDENT_W-1:0]  ident_in_reg;
    logic [spq_pkg::PRIO_W-1:0]   prio_in_reg;

    // result registers
    logic [spq_pkg::STATUS_W-1:0] status_reg;
    logic [spq_pkg::STATUS_W-1:0] status_next;
    logic [spq_pkg::IDENT_W-1:0]  out_ident_reg;
    logic [spq_pkg::IDENT_W-1:0]  out_ident_next;
    logic [spq_pkg::PRIO_W-1:0]   out_priority_reg;
    logic [spq_pkg::PRIO_W-1:0]   out_priority_next;
    logic [spq_pkg::HELD_W-1:0]   held_reg;
    logic [CNT_W+spq_pkg::HELD_W-1:0] held_ext;

    logic             full;
    logic             empty;
    logic             do_insert;
    logic             do_pop;
    logic [DEPTH-1:0] ge;

    // capture the operation at transfer
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg     <= kind;
            ident_in_reg <= job_ident;
            prio_in_reg  <= job_priority;
        end
    end

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    // operation decode and result
    always_comb
    begin
        count_next        = count_reg;
        status_next       = spq_pkg::ST_OK;
        out_ident_next    = '0;
        out_priority_next = '0;
        do_insert         = 1'b0;
        do_pop            = 1'b0;
        unique case (kind_reg) inside
            spq_pkg::KIND_INSERT:
            begin
                if (full)
                begin
                    status_next = spq_pkg::ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    do_insert  = cmd.exec;
                end
            end
            spq_pkg::KIND_POP, spq_pkg::KIND_PEEK:
            begin
                if (empty)
                begin
                    status_next = spq_pkg::ST_EMPTY;
                end
                else
                begin
                    out_ident_next    = slot_ident_reg[0];
                    out_priority_next = slot_priority_reg[0];
                    if (kind_reg == spq_pkg::KIND_POP)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        do_pop     = cmd.exec;
                    end
                end
            end
            default:
            begin
                status_next = spq_pkg::ST_OK;
            end
        endcase
    end

    // per-cell compare: held and of equal or higher priority, a prefix of the row
    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            assign ge[i] = (CNT_W'(i) < count_reg) && (slot_priority_reg[i] >= prio_in_reg);

            if (i == 0)
            begin : g_front
                // front cell: takes the new job or the one behind it
                always_ff @(posedge clk)
                begin
                    if (do_insert && !ge[0])
                    begin
                        slot_ident_reg[0]    <= ident_in_reg;
                        slot_priority_reg[0] <= prio_in_reg;
                    end
                    else if (do_pop && (DEPTH > 1))
                    begin
                        slot_ident_reg[0]    <= slot_ident_reg[(DEPTH > 1) ? 1 : 0];
                        slot_priority_reg[0] <= slot_priority_reg[(DEPTH > 1) ? 1 : 0];
                    end
                end
            end
            else if (i == DEPTH - 1)
            begin : g_back
                // back cell: takes the new job or the one ahead of it
                always_ff @(posedge clk)
                begin
                    if (do_insert && !ge[i])
                    begin
                        if (ge[i-1])
                        begin
                            slot_ident_reg[i]    <= ident_in_reg;
                            slot_priority_reg[i] <= prio_in_reg;
                        end
                        else
                        begin
                            slot_ident_reg[i]    <= slot_ident_reg[i-1];
                            slot_priority_reg[i] <= slot_priority_reg[i-1];
                        end
                    end
                end
            end
            else
            begin : g_mid
                // middle cell: new job, shift back, or shift forward
                always_ff @(posedge clk)
                begin
                    if (do_insert && !ge[i])
                    begin
                        if (ge[i-1])
                        begin
                            slot_ident_reg[i]    <= ident_in_reg;
                            slot_priority_reg[i] <= prio_in_reg;
                        end
                        else
                        begin
                            slot_ident_reg[i]    <= slot_ident_reg[i-1];
                            slot_priority_reg[i] <= slot_priority_reg[i-1];
                        end
                    end
                    else if (do_pop)
                    begin
                        slot_ident_reg[i]    <= slot_ident_reg[i+1];
                        slot_priority_reg[i] <= slot_priority_reg[i+1];
                    end
                end
            end
        end
    endgenerate

    // fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
        end
    end

    // held count is the fill count masked to the port width
    assign held_ext = {{spq_pkg::HELD_W{1'b0}}, count_next};

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            status_reg       <= status_next;
            out_ident_reg    <= out_ident_next;
            out_priority_reg <= out_priority_next;
            held_reg         <= held_ext[spq_pkg::HELD_W-1:0];
        end
    end

    assign status       = status_reg;
    assign out_ident    = out_ident_reg;
    assign out_priority = out_priority_reg;
    assign held_count   = held_reg;

endmodule

// File: hdl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// job queue kept sorted highest priority first, insert / pop / peek commands
//
//   channel   direction   handshake              payload
//   command   in          start, busy            kind, job_ident, job_priority
//   result    out         done (one-cycle pulse) status, out_ident,
//                                                out_priority, held_count
//
// every command is transferred, executed in the slot cells while busy is
// high, then done pulses with the result while a new command is taken.
// all slots compare and shift in parallel, so the cost does not grow with
// fill level. reset clears the sequencer and fill count only; slot contents need no reset.
// results cannot be stalled; they are held on the ports until the next one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_priority_queue
#(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [spq_pkg::KIND_W-1:0]   kind,
    input  logic [spq_pkg::IDENT_W-1:0]  job_ident,
    input  logic [spq_pkg::PRIO_W-1:0]   job_priority,
    output logic                         done,
    output logic [spq_pkg::STATUS_W-1:0] status,
    output logic [spq_pkg::IDENT_W-1:0]  out_ident,
    output logic [spq_pkg::PRIO_W-1:0]   out_priority,
    output logic [spq_pkg::HELD_W-1:0]   held_count
);

    spq_pkg::spq_cmd_t cmd;

    // sequencer
    spq_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // slot cells and result registers
    spq_dp #(
        .DEPTH (DEPTH)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .kind         (kind),
        .job_ident    (job_ident),
        .job_priority (job_priority),
        .status       (status),
        .out_ident    (out_ident),
        .out_priority (out_priority),
        .held_count   (held_count)
    );

endmodule

// File: hdl/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// port-level checks of command and result timing, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_priority_queue_defines.svh"

module spq_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         done,
    input logic [spq_pkg::STATUS_W-1:0] status,
    input logic [spq_pkg::IDENT_W-1:0]  out_ident,
    input logic [spq_pkg::PRIO_W-1:0]   out_priority,
    input logic [spq_pkg::HELD_W-1:0]   held_count
);

    logic empty_rpt;
    logic rpt_clear;

    // empty report and cleared payload
    assign empty_rpt = done && (status == spq_pkg::ST_EMPTY);
    assign rpt_clear = (out_ident == '0) && (out_priority == '0) && (held_count == '0);

    // a transfer makes the block busy for the execute cycle
    `SPQ_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy, "transfer did not raise busy")

    // the execute cycle is followed by exactly one result
    `SPQ_ASSERT_NXT(a_busy_done, clk, rst_n, busy, done && !busy, "no result after execute")

    // a result never lands while a command is executing
    `SPQ_ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy, "result while busy")

    // an empty report carries no job and an empty count
    `SPQ_ASSERT_IMP(a_empty_zero, clk, rst_n, empty_rpt, rpt_clear, "empty result not cleared")

endmodule

bind sorted_priority_queue spq_checker u_spq_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .out_ident    (out_ident),
    .out_priority (out_priority),
    .held_count   (held_count)
);

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench for sorted_priority_queue
// drives insert, pop, peek and unused-code commands through the start / busy
// handshake with random idle gaps, tracks the sorted job list in a local
// model and compares every done pulse against the oldest predicted result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int SLOTS        = spq_pkg::DEPTH_DEF;
    localparam int RANDOM_ITEMS = 1250;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 10;

    // unused operation code, answered as a no-op
    localparam logic [spq_pkg::KIND_W-1:0] KIND_NOP = 2'd3;

    typedef struct packed {
        logic [spq_pkg::KIND_W-1:0]  kind;
        logic [spq_pkg::IDENT_W-1:0] ident;
        logic [spq_pkg::PRIO_W-1:0]  prio;
    } job_op_t;

    typedef struct packed {
        logic [spq_pkg::STATUS_W-1:0] status;
        logic [spq_pkg::IDENT_W-1:0]  ident;
        logic [spq_pkg::PRIO_W-1:0]   prio;
        logic [spq_pkg::HELD_W-1:0]   held;
    } job_result_t;

    logic                         clk          = 1'b0;
    logic                         rst_n        = 1'b0;
    logic                         start        = 1'b0;
    logic [spq_pkg::KIND_W-1:0]   kind         = spq_pkg::KIND_INSERT;
    logic [spq_pkg::IDENT_W-1:0]  job_ident    = '0;
    logic [spq_pkg::PRIO_W-1:0]   job_priority = '0;
    logic                         busy;
    logic                         done;
    logic [spq_pkg::STATUS_W-1:0] status;
    logic [spq_pkg::IDENT_W-1:0]  out_ident;
    logic [spq_pkg::PRIO_W-1:0]   out_priority;
    logic [spq_pkg::HELD_W-1:0]   held_count;

    // commands waiting to be driven and results waiting to come back
    job_op_t     job_ops[$];
    job_result_t due_results[$];

    // local copy of the sorted job list
    logic [spq_pkg::IDENT_W-1:0] list_ident[SLOTS];
    logic [spq_pkg::PRIO_W-1:0]  list_prio[SLOTS];
    int                          list_len = 0;

    // fill level seen while building the command list
    int gen_level = 0;

    // idle control of the driver
    int gap_left  = 0;
    int calm_left = 0;

    int errors      = 0;
    int cycle_count = 0;
    int n_insert    = 0;
    int n_dropped   = 0;
    int n_pop       = 0;
    int n_peek      = 0;
    int n_empty     = 0;
    int n_nop       = 0;
    int max_fill    = 0;

    sorted_priority_queue uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .job_ident    (job_ident),
        .job_priority (job_priority),
        .done         (done),
        .status       (status),
        .out_ident    (out_ident),
        .out_priority (out_priority),
        .held_count   (held_count)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // apply one command to the local job list and form its result
    task automatic apply_job_op(input job_op_t op, output job_result_t res);
        int pos;
        res = '0;
        pos = 0;
        case (op.kind) inside
            spq_pkg::KIND_INSERT:
            begin
                if (list_len >= SLOTS)
                begin
                    res.status = spq_pkg::ST_FULL;
                    n_dropped++;
                end
                else
                begin
                    // goes behind every job of equal or higher priority
                    while (pos < list_len && list_prio[pos] >= op.prio)
                        pos++;
                    for (int i = list_len; i > pos; i--)
                    begin
                        list_ident[i] = list_ident[i-1];
                        list_prio[i]  = list_prio[i-1];
                    end
                    list_ident[pos] = op.ident;
                    list_prio[pos]  = op.prio;
                    list_len++;
                    n_insert++;
                    if (list_len > max_fill)
                        max_fill = list_len;
                end
            end
            spq_pkg::KIND_POP, spq_pkg::KIND_PEEK:
            begin
                if (list_len == 0)
                begin
                    res.status = spq_pkg::ST_EMPTY;
                    n_empty++;
                end
                else
                begin
                    res.ident = list_ident[0];
                    res.prio  = list_prio[0];
                    if (op.kind == spq_pkg::KIND_POP)
                    begin
                        for (int i = 1; i < list_len; i++)
                        begin
                            list_ident[i-1] = list_ident[i];
                            list_prio[i-1]  = list_prio[i];
                        end
                        list_len--;
                        n_pop++;
                    end
                    else
                        n_peek++;
                end
            end
            default:
                n_nop++;
        endcase
        res.held = spq_pkg::HELD_W'(list_len);
    endtask

    // idle cycles before the next command: mostly none or short, a few long
    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if (r < 3)
        begin
            calm_left = $urandom_range(30, 100);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // priorities lean on a few values so that ties happen often
    function automatic int rand_prio();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return $urandom_range(0, 255);
        if (r < 7)
        begin
            case ($urandom_range(0, 3))
                0: return 0;
                1: return 1;
                2: return 128;
                default: return 255;
            endcase
        end
        return $urandom_range(100, 103);
    endfunction

    function automatic int rand_ident();
        case ($urandom_range(0, 15))
            0: return 0;
            1: return 16'hffff;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    task automatic add_op(input logic [spq_pkg::KIND_W-1:0] k, input int id, input int pr);
        job_op_t op;
        op.kind  = k;
        op.ident = spq_pkg::IDENT_W'(id);
        op.prio  = spq_pkg::PRIO_W'(pr);
        job_ops.push_back(op);
        if (k == spq_pkg::KIND_INSERT && gen_level < SLOTS)
            gen_level++;
        else if (k == spq_pkg::KIND_POP && gen_level > 0)
            gen_level--;
    endtask

    // driver: present commands from the list, hold each until transfer
    always @(posedge clk)
    begin : drive_proc
        job_result_t want;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                apply_job_op({kind, job_ident, job_priority}, want);
                due_results.push_back(want);
            end
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (job_ops.size() != 0)
                begin
                    kind         <= job_ops[0].kind;
                    job_ident    <= job_ops[0].ident;
                    job_priority <= job_ops[0].prio;
                    void'(job_ops.pop_front());
                    start        <= 1'b1;
                    gap_left = next_gap();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor: every done pulse is checked against the oldest prediction
    always @(posedge clk)
    begin : watch_proc
        job_result_t got;
        job_result_t want;
        if (rst_n && done)
        begin
            got = {status, out_ident, out_priority, held_count};
            if (due_results.size() == 0)
            begin
                $display("%0t: unexpected result status %0d ident %h prio %0d held %0d",
                         $time, got.status, got.ident, got.prio, got.held);
                errors++;
            end
            else
            begin
                want = due_results.pop_front();
                if (got !== want)
                begin
                    $display("%0t: result mismatch expected status %0d ident %h prio %0d held %0d",
                             $time, want.status, want.ident, want.prio, want.held);
                    $display("%0t:                 actual   status %0d ident %h prio %0d held %0d",
                             $time, got.status, got.ident, got.prio, got.held);
                    errors++;
                end
            end
        end
    end

    // timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    // command list, reset and end of run
    initial
    begin : main_proc
        int target;
        int mode;
        int r;

        // directed: empty reads, extremes, ties, no-op, drain past empty
        add_op(spq_pkg::KIND_POP, 0, 0);
        add_op(spq_pkg::KIND_PEEK, 16'hffff, 255);
        add_op(KIND_NOP, 16'hffff, 255);
        add_op(spq_pkg::KIND_INSERT, 16'hffff, 255);
        add_op(spq_pkg::KIND_INSERT, 0, 0);
        add_op(spq_pkg::KIND_INSERT, 16'h1234, 255);
        add_op(spq_pkg::KIND_INSERT, 16'haaaa, 128);
        add_op(spq_pkg::KIND_INSERT, 16'h5555, 0);
        add_op(spq_pkg::KIND_INSERT, 16'h00ff, 128);
        add_op(spq_pkg::KIND_PEEK, 0, 0);
        add_op(KIND_NOP, 0, 0);
        add_op(spq_pkg::KIND_POP, 0, 0);
        add_op(spq_pkg::KIND_PEEK, 0, 0);
        add_op(spq_pkg::KIND_POP, 0, 0);
        add_op(spq_pkg::KIND_POP, 0, 0);
        add_op(spq_pkg::KIND_POP, 0, 0);
        add_op(spq_pkg::KIND_POP, 0, 0);
        add_op(spq_pkg::KIND_POP, 0, 0);
        add_op(spq_pkg::KIND_POP, 0, 0);
        add_op(spq_pkg::KIND_PEEK, 0, 0);

        // random: fill to overflow, drain past empty, mixed traffic, noise
        target = job_ops.size() + RANDOM_ITEMS;
        while (job_ops.size() < target)
        begin
            mode = $urandom_range(0, 9);
            if (mode < 3)
            begin
                while (gen_level < SLOTS)
                    add_op(spq_pkg::KIND_INSERT, rand_ident(), rand_prio());
                repeat ($urandom_range(1, 3))
                    add_op(spq_pkg::KIND_INSERT, rand_ident(), rand_prio());
                add_op(spq_pkg::KIND_PEEK, rand_ident(), rand_prio());
            end
            else if (mode < 6)
            begin
                while (gen_level > 0)
                    add_op(($urandom_range(0, 3) == 0) ? spq_pkg::KIND_PEEK : spq_pkg::KIND_POP,
                           rand_ident(), rand_prio());
                repeat ($urandom_range(1, 2))
                    add_op(($urandom_range(0, 1) == 0) ? spq_pkg::KIND_PEEK : spq_pkg::KIND_POP,
                           rand_ident(), rand_prio());
            end
            else if (mode < 9)
            begin
                repeat ($urandom_range(5, 30))
                begin
                    r = $urandom_range(0, 99);
                    if (r < 50)
                        add_op(spq_pkg::KIND_INSERT, rand_ident(), rand_prio());
                    else if (r < 80)
                        add_op(spq_pkg::KIND_POP, rand_ident(), rand_prio());
                    else if (r < 98)
                        add_op(spq_pkg::KIND_PEEK, rand_ident(), rand_prio());
                    else
                        add_op(KIND_NOP, rand_ident(), rand_prio());
                end
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    add_op(KIND_NOP, rand_ident(), rand_prio());
            end
        end

        // hold reset, then release it
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // wait for every command to transfer and every result to return
        while (job_ops.size() != 0 || start || due_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d inserts, %0d dropped when full, %0d pops, %0d peeks",
                 n_insert, n_dropped, n_pop, n_peek);
        $display("plus %0d empty reads and %0d no-ops, fill reached %0d of %0d, %0d errors",
                 n_empty, n_nop, max_fill, SLOTS, errors);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: sorted_priority_queue.f
+incdir+hdl
hdl/spq_pkg.sv
hdl/spq_ctrl.sv
hdl/spq_dp.sv
hdl/sorted_priority_queue.sv
hdl/spq_checker.sv
tb/sv/testbench.sv
